### rtl/bsm_pkg.sv
package bsm_pkg;

  // Field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned OFFSET_W = 19;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned BANK_W   = 8;
  localparam int unsigned PRG_W    = 6;
  localparam int unsigned NUM_BANK_REGS = 8;
  localparam int unsigned SEL_W    = $clog2(NUM_BANK_REGS);
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = COUNT_W;

  // Default number of program banks the window logic is sized for
  localparam int unsigned MAX_PRG_BANKS_DEF = 64;

  // Operation codes on the input word
  localparam logic [FUNC_W-1:0] FUNC_CPU_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CPU_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PPU       = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED    = 2'd3;

  // CPU register pair select, address bits 14..13
  localparam logic [1:0] REGION_BANK   = 2'd0;
  localparam logic [1:0] REGION_MIRROR = 2'd1;
  localparam logic [1:0] REGION_IRQ_CNT = 2'd2;
  localparam logic [1:0] REGION_IRQ_EN = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOUR_SCREEN    = 1'b1;

  localparam logic [COUNT_W-1:0] PRG_BANK_COUNT_RST = 7'd64;

  typedef logic [BANK_W-1:0] bank_t;

  // Bank register contents after reset
  localparam bank_t BANK_RST [NUM_BANK_REGS] = '{
    8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd1
  };

endpackage

### rtl/bank_switch_mapper_irq_counter.sv
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall   in_func, in_address, in_data
// out_      output     out_valid/out_stall out_rom_offset, out_irq_pending,
//                                         out_mirror_horizontal
// cfg_      input      cfg_we              cfg_index, cfg_data
//
// One word per cycle while the output is not stalled; a taken word goes through both registers.
// The input register feeds a single pass of decode, bank lookup and counter
// update that loads the output register, so latency is set by those two
// registers. rst_n clears control state and the bank registers to their
// startup values. A stall on the output holds both registers and backs up
// into in_stall in the same cycle once the input register is full.
module bank_switch_mapper_irq_counter
  import bsm_pkg::*;
#(
  parameter int unsigned MAX_PRG_BANKS = MAX_PRG_BANKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bsm_pkg::FUNC_W-1:0]        in_func,
  input  logic [bsm_pkg::ADDR_W-1:0]        in_address,
  input  logic [bsm_pkg::DATA_W-1:0]        in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bsm_pkg::OFFSET_W-1:0]      out_rom_offset,
  output logic                              out_irq_pending,
  output logic                              out_mirror_horizontal,
  input  logic                              cfg_we,
  input  logic [bsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bsm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_PRG_BANKS);

  // Configuration
  logic [COUNT_W-1:0] prg_bank_count_r;
  logic               four_screen_r;

  // Input register
  logic              s1_valid_r;
  logic [FUNC_W-1:0] s1_func_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [DATA_W-1:0] s1_data_r;

  // Mapper state
  bank_t             bank_r [NUM_BANK_REGS];
  logic [SEL_W-1:0]  sel_r;
  logic              prg_swap_r;
  logic              chr_invert_r;
  logic [BANK_W-1:0] latch_r;
  logic [BANK_W-1:0] counter_r;
  logic              last_a12_r;
  logic              irq_en_r;
  logic              irq_flag_r;
  logic              mirror_r;

  // Output register
  logic                out_valid_r;
  logic [OFFSET_W-1:0] out_offset_r;
  logic                out_irq_r;
  logic                out_mirror_r;

  logic advance;
  logic s1_load;

  // Next values
  logic              bank_we;
  logic [SEL_W-1:0]  sel_nxt;
  logic              prg_swap_nxt;
  logic              chr_invert_nxt;
  logic [BANK_W-1:0] latch_nxt;
  logic [BANK_W-1:0] counter_nxt;
  logic              last_a12_nxt;
  logic              irq_en_nxt;
  logic              irq_flag_nxt;
  logic              mirror_nxt;
  logic [OFFSET_W-1:0] offset_nxt;

  // Translation helpers
  logic [COUNT_W-1:0] count_eff;
  logic [PRG_W-1:0]   second_last;
  logic [PRG_W-1:0]   last_bank;
  logic [PRG_W-1:0]   prg_bank;
  logic [2:0]         chr_slot;
  logic [2:0]         chr_idx;
  bank_t              chr_bank;
  logic               a12;

  // Move the output register when empty or taken; the input register loads
  // when it is empty or its word moves on
  assign advance   = !out_valid_r || !out_stall;
  assign s1_load   = advance || !s1_valid_r;
  assign in_stall  = !s1_load;

  assign out_valid             = out_valid_r;
  assign out_rom_offset        = out_offset_r;
  assign out_irq_pending       = out_irq_r;
  assign out_mirror_horizontal = out_mirror_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_bank_count_r <= PRG_BANK_COUNT_RST;
      four_screen_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRG_BANK_COUNT: prg_bank_count_r <= cfg_data;
        CFG_FOUR_SCREEN:    four_screen_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_func_r <= in_func;
      s1_addr_r <= in_address;
      s1_data_r <= in_data;
    end
  end

  // Program windows: clamp the count, fixed banks wrap to six bits
  always_comb begin
    count_eff   = (prg_bank_count_r > MaxCount) ? MaxCount : prg_bank_count_r;
    second_last = PRG_W'(count_eff - COUNT_W'(2));
    last_bank   = PRG_W'(count_eff - COUNT_W'(1));
    unique case (s1_addr_r[14:13])
      REGION_BANK:    prg_bank = prg_swap_r ? second_last : bank_r[6][PRG_W-1:0];
      REGION_MIRROR:  prg_bank = bank_r[7][PRG_W-1:0];
      REGION_IRQ_CNT: prg_bank = prg_swap_r ? bank_r[6][PRG_W-1:0] : second_last;
      REGION_IRQ_EN:  prg_bank = last_bank;
      default:        prg_bank = last_bank;
    endcase
  end

  // Pattern slots: two 2 KB pairs then four 1 KB banks
  always_comb begin
    chr_slot = s1_addr_r[12:10] ^ {chr_invert_r, 2'b00};
    chr_idx  = chr_slot - 3'd2;
    if (!chr_slot[2]) begin
      chr_bank = {bank_r[{2'b00, chr_slot[1]}][BANK_W-1:1], chr_slot[0]};
    end else begin
      chr_bank = bank_r[chr_idx];
    end
  end

  assign a12 = s1_addr_r[12];

  // Decode the word and work out the next state and result
  always_comb begin
    bank_we        = 1'b0;
    sel_nxt        = sel_r;
    prg_swap_nxt   = prg_swap_r;
    chr_invert_nxt = chr_invert_r;
    latch_nxt      = latch_r;
    counter_nxt    = counter_r;
    last_a12_nxt   = last_a12_r;
    irq_en_nxt     = irq_en_r;
    irq_flag_nxt   = irq_flag_r;
    mirror_nxt     = mirror_r;
    offset_nxt     = '0;
    unique case (s1_func_r)
      FUNC_CPU_WRITE: begin
        if (s1_addr_r[15]) begin
          unique case (s1_addr_r[14:13])
            REGION_BANK: begin
              if (!s1_addr_r[0]) begin
                sel_nxt        = s1_data_r[SEL_W-1:0];
                prg_swap_nxt   = s1_data_r[6];
                chr_invert_nxt = s1_data_r[7];
              end else begin
                bank_we = 1'b1;
              end
            end
            REGION_MIRROR: begin
              if (!s1_addr_r[0] && !four_screen_r) begin
                mirror_nxt = s1_data_r[0];
              end
            end
            REGION_IRQ_CNT: begin
              if (!s1_addr_r[0]) begin
                latch_nxt = s1_data_r;
              end else begin
                counter_nxt = '0;
              end
            end
            REGION_IRQ_EN: begin
              if (!s1_addr_r[0]) begin
                irq_en_nxt   = 1'b0;
                irq_flag_nxt = 1'b0;
              end else begin
                irq_en_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      FUNC_CPU_READ: begin
        if (s1_addr_r[15]) begin
          offset_nxt = {prg_bank, s1_addr_r[12:0]};
        end
      end
      FUNC_PPU: begin
        // Count rising edges of address bit 12
        if (a12 && !last_a12_r) begin
          if (counter_r == '0) begin
            counter_nxt = latch_r;
            if (irq_en_r) begin
              irq_flag_nxt = 1'b1;
            end
          end else begin
            counter_nxt = counter_r - BANK_W'(1);
          end
        end
        last_a12_nxt = a12;
        if (!s1_addr_r[13]) begin
          offset_nxt = OFFSET_W'({chr_bank, s1_addr_r[9:0]});
        end
      end
      FUNC_UNUSED: ;
      default: ;
    endcase
  end

  // Update mapper state once per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BANK_REGS; i++) begin
        bank_r[i] <= BANK_RST[i];
      end
      sel_r        <= '0;
      prg_swap_r   <= 1'b0;
      chr_invert_r <= 1'b0;
      latch_r      <= '0;
      counter_r    <= '0;
      last_a12_r   <= 1'b0;
      irq_en_r     <= 1'b0;
      irq_flag_r   <= 1'b0;
      mirror_r     <= 1'b0;
    end else if (advance && s1_valid_r) begin
      if (bank_we) begin
        bank_r[sel_r] <= s1_data_r;
      end
      sel_r        <= sel_nxt;
      prg_swap_r   <= prg_swap_nxt;
      chr_invert_r <= chr_invert_nxt;
      latch_r      <= latch_nxt;
      counter_r    <= counter_nxt;
      last_a12_r   <= last_a12_nxt;
      irq_en_r     <= irq_en_nxt;
      irq_flag_r   <= irq_flag_nxt;
      mirror_r     <= mirror_nxt;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_offset_r <= offset_nxt;
      out_irq_r    <= irq_flag_nxt;
      out_mirror_r <= mirror_nxt;
    end
  end

endmodule
